### sv/ptc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants of the permission table check
// Request codes, register indexes, the table entry layout and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned PERM_W  = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_A_W = 8;
  localparam int unsigned CFG_D_W = 32;

  localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OP_W-1:0] OP_GRANT  = 2'd1;
  localparam logic [OP_W-1:0] OP_REVOKE = 2'd2;

  localparam logic [CFG_A_W-1:0] REG_OWNER_ID   = 8'd0;
  localparam logic [CFG_A_W-1:0] REG_OTHER_PERM = 8'd1;

  localparam logic [ID_W-1:0] ROOT_ID = 32'd0;

  typedef struct packed {
    logic [ID_W-1:0]   client;
    logic [PERM_W-1:0] perm;
  } entry_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
  } dp_sts_t;

endpackage
`default_nettype wire

### sv/ptc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_ctrl: request sequencer of the permission table check
// Accepts a request, runs the table scan until a hit or the end of the stored
// entries, then finishes the request into the output register.
// ----------------------------------------------------------------------------
module ptc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire ptc_pkg::dp_sts_t sts,
  output ptc_pkg::dp_cmd_t      cmd
);
  import ptc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  logic   fin;

  assign fin        = (state == S_FINISH) && (!out_valid || out_ready);
  assign in_ready   = (state == S_IDLE);
  assign cmd.start  = (state == S_IDLE) && in_valid;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.finish = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.hit || sts.scan_end) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/ptc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_datapath: client table, configuration and result logic
// Holds the client memory with its fill count, scans it one entry per cycle
// and computes the answer and the table update of the captured request.
// ----------------------------------------------------------------------------
module ptc_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [ptc_pkg::OP_W-1:0]       opcode,
  input  wire logic [ptc_pkg::ID_W-1:0]       client_id,
  input  wire logic [ptc_pkg::PERM_W-1:0]     perm_mask,
  input  wire logic                           cfg_we,
  input  wire logic [ptc_pkg::CFG_A_W-1:0]    cfg_index,
  input  wire logic [ptc_pkg::CFG_D_W-1:0]    cfg_data,
  input  wire ptc_pkg::dp_cmd_t               cmd,
  output ptc_pkg::dp_sts_t                    sts,
  output logic                                granted,
  output logic                                table_full
);
  import ptc_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] DEPTH = CW'(TABLE_ENTRIES);

  entry_t mem [TABLE_ENTRIES];

  logic [ID_W-1:0]   owner_id;
  logic [PERM_W-1:0] other_perm;
  logic [OP_W-1:0]   req_op;
  logic [ID_W-1:0]   req_cid;
  logic [PERM_W-1:0] req_mask;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     scan_ptr;
  logic              rd_vld;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_data;
  logic              found;
  logic [AW-1:0]     found_slot;
  logic [PERM_W-1:0] found_perm;

  logic              issue_ok;
  logic [PERM_W-1:0] base_perm;
  logic [PERM_W-1:0] perm_next;
  logic              granted_next;
  logic              full_next;
  logic              wr_en;
  logic              alloc;
  logic [AW-1:0]     wr_addr;

  assign issue_ok     = (scan_ptr < cnt);
  assign sts.hit      = rd_vld && (rd_data.client == req_cid);
  assign sts.scan_end = !rd_vld && !issue_ok;

  assign base_perm = found ? found_perm : other_perm;
  assign perm_next = (req_op == OP_GRANT) ? (base_perm | req_mask)
                                          : (base_perm & ~req_mask);

  always_comb begin
    granted_next = 1'b0;
    full_next    = 1'b0;
    wr_en        = 1'b0;
    alloc        = 1'b0;
    wr_addr      = found_slot;
    unique case (req_op)
      OP_CHECK: begin
        granted_next = (req_cid == ROOT_ID) || (req_cid == owner_id) ||
                       ((base_perm & req_mask) != '0);
      end
      OP_GRANT, OP_REVOKE: begin
        if (req_cid == owner_id) begin
          granted_next = (req_op == OP_GRANT);
        end else if (found) begin
          wr_en        = cmd.finish;
          granted_next = 1'b1;
        end else if (cnt < DEPTH) begin
          wr_en        = cmd.finish;
          alloc        = 1'b1;
          wr_addr      = cnt[AW-1:0];
          granted_next = 1'b1;
        end else begin
          full_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && issue_ok) begin
      rd_data <= mem[scan_ptr[AW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= '{client: req_cid, perm: perm_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_id   <= '0;
      other_perm <= '0;
      cnt        <= '0;
      scan_ptr   <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OWNER_ID) begin
          owner_id <= cfg_data[ID_W-1:0];
        end else if (cfg_index == REG_OTHER_PERM) begin
          other_perm <= cfg_data[PERM_W-1:0];
        end
      end
      if (cmd.start) begin
        req_op   <= opcode;
        req_cid  <= client_id;
        req_mask <= perm_mask;
        scan_ptr <= '0;
        rd_vld   <= 1'b0;
        found    <= 1'b0;
      end
      if (cmd.scan) begin
        rd_vld  <= issue_ok;
        rd_addr <= scan_ptr[AW-1:0];
        if (issue_ok) begin
          scan_ptr <= scan_ptr + CW'(1);
        end
        if (sts.hit) begin
          found      <= 1'b1;
          found_slot <= rd_addr;
          found_perm <= rd_data.perm;
        end
      end
      if (cmd.finish) begin
        granted    <= granted_next;
        table_full <= full_next;
        if (alloc) begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/permission_table_check_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// permission_table_check_top: per-client permission table
// Answers check, grant and revoke requests against a table of clients.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    opcode, client_id, perm_mask
//   output    out_valid / out_ready  granted, table_full
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request passes the accept, scan and finish steps before the next accept;
// the scan stops at the first stored client that hits or after the last one,
// and the client memory is read one entry per cycle.
// Reset clears the fill count, the config registers and the control state; the
// memory needs no clearing pass. A result waits in the output register while
// the next request is taken, and a stalled output only holds the finish step.
// ----------------------------------------------------------------------------
module permission_table_check_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ptc_pkg::OP_W-1:0]    opcode,
  input  wire logic [ptc_pkg::ID_W-1:0]    client_id,
  input  wire logic [ptc_pkg::PERM_W-1:0]  perm_mask,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             granted,
  output logic                             table_full,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ptc_pkg::CFG_A_W-1:0] cfg_index,
  input  wire logic [ptc_pkg::CFG_D_W-1:0] cfg_data
);
  import ptc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  ptc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .opcode     (opcode),
    .client_id  (client_id),
    .perm_mask  (perm_mask),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .granted    (granted),
    .table_full (table_full)
  );

endmodule
`default_nettype wire
